// ===== src/grc_pkg.sv =====
`timescale 1ns / 1ps

package grc_pkg;

  localparam int IMAGE_SIZE_DEF = 256;
  localparam int COORD_W        = 8;
  localparam int DIST_W         = 17;
  localparam int ERR_W          = 11;
  localparam int SQ_W           = 16;
  localparam int CFG_AW         = 3;
  localparam int CFG_DW         = 32;

  localparam logic [COORD_W-1:0] OCCUPIED_VALUE  = 8'd255;
  localparam logic [COORD_W-1:0] ORIGIN_COL_RST  = 8'd127;
  localparam logic [COORD_W-1:0] ORIGIN_ROW_RST  = 8'd127;
  localparam logic [DIST_W-1:0]  DIST_MAX        = 17'h1FFFF;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CAST  = 1'b1;

  // Register index as decoded from paddr[2].
  localparam logic REG_ORIGIN_COL = 1'b0;
  localparam logic REG_ORIGIN_ROW = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] min_sq_distance;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } grc_state_t;

  // Distance reported when no occupied pixel lies on the ray.
  function automatic logic [DIST_W-1:0] grc_no_hit(input int size);
    longint sq;
    sq = longint'(size) * longint'(size);
    if (sq > longint'(DIST_MAX)) begin
      return DIST_MAX;
    end
    return DIST_W'(sq);
  endfunction

endpackage

// ===== src/grc_occ_mem.sv =====
`timescale 1ns / 1ps

module grc_occ_mem import grc_pkg::*; #(
  parameter int IMAGE_SIZE = IMAGE_SIZE_DEF,
  parameter int AW         = $clog2(IMAGE_SIZE * IMAGE_SIZE)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data
);

  localparam int DEPTH = IMAGE_SIZE * IMAGE_SIZE;

  logic mem [DEPTH];
  logic rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/grid_ray_cast_depth.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_item_t (kind, col, row, pixel_value)
// out_      output     out_valid/out_stall  out_item_t (hit, min_sq_distance)
// cfg_      input      APB write/read       origin_col at 0x0, origin_row at 0x4
//
// A pixel write leaves the block idle, so it is ready again in the next cycle.
// A cast steps through a setup state, a walk state that reads one line pixel per
// cycle through the occupancy memory read port, a drain state and a finish state.
// in_stall stays high from a cast transaction until its result is loaded into
// the output register; a waiting result blocks a later cast only in its finish state.
// rst_n is synchronous; the occupancy memory is not cleared by reset.

module grid_ray_cast_depth import grc_pkg::*; #(
  parameter int IMAGE_SIZE = IMAGE_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int AW = $clog2(IMAGE_SIZE * IMAGE_SIZE);
  localparam logic [DIST_W-1:0] NO_HIT = grc_no_hit(IMAGE_SIZE);

  grc_state_t state_r, state_nxt;

  logic [COORD_W-1:0] ocol_r, orow_r;
  logic [COORD_W-1:0] tcol_r, trow_r;
  logic [COORD_W-1:0] x_r, y_r, end_r;
  logic               xmaj_r, minor_up_r;
  logic signed [ERR_W-1:0] err_r, inc_lo_r, inc_hi_r;

  logic              pv_r;
  logic [SQ_W-1:0]   sq_c_r, sq_r_r;
  logic              hit_r;
  logic [DIST_W-1:0] best_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  logic in_acc, cast_acc, wr_acc, cfg_wr;
  logic setup_en, walk_en, load_out;
  logic at_end, out_free;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocol_r <= ORIGIN_COL_RST;
      orow_r <= ORIGIN_ROW_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_ORIGIN_COL) begin
        ocol_r <= cfg_pwdata[COORD_W-1:0];
      end else begin
        orow_r <= cfg_pwdata[COORD_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_ORIGIN_ROW) begin
      cfg_prdata = CFG_DW'(orow_r);
    end else begin
      cfg_prdata = CFG_DW'(ocol_r);
    end
  end

  // ---------------- input handshake ----------------
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign cast_acc = in_acc && (in_data.kind == KIND_CAST);
  assign wr_acc   = in_acc && (in_data.kind == KIND_WRITE);

  always_ff @(posedge clk) begin
    if (cast_acc) begin
      tcol_r <= in_data.col;
      trow_r <= in_data.row;
    end
  end

  // ---------------- sequencer ----------------
  assign at_end   = ((xmaj_r ? x_r : y_r) == end_r);
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (cast_acc) state_nxt = ST_SETUP;
      ST_SETUP:  state_nxt = ST_WALK;
      ST_WALK:   if (at_end) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_FINISH;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    setup_en = 1'b0;
    walk_en  = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      ST_SETUP:  setup_en = 1'b1;
      ST_WALK:   walk_en  = 1'b1;
      ST_FINISH: load_out = out_free;
      default: ;
    endcase
  end

  // ---------------- line setup and stepping ----------------
  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W-1:0] adx, ady;
  logic               same_sign, xmaj;
  logic [ERR_W-1:0]   maj_ext, min_ext;

  always_comb begin
    dx        = $signed({1'b0, tcol_r}) - $signed({1'b0, ocol_r});
    dy        = $signed({1'b0, trow_r}) - $signed({1'b0, orow_r});
    adx       = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ady       = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    same_sign = (dx[COORD_W] && dy[COORD_W]) ||
                (!dx[COORD_W] && dx != '0 && !dy[COORD_W] && dy != '0);
    xmaj      = (ady <= adx);
    maj_ext   = xmaj ? ERR_W'(adx) : ERR_W'(ady);
    min_ext   = xmaj ? ERR_W'(ady) : ERR_W'(adx);
  end

  always_ff @(posedge clk) begin
    if (setup_en) begin
      xmaj_r     <= xmaj;
      minor_up_r <= same_sign;
      err_r      <= $signed((min_ext << 1) - maj_ext);
      inc_lo_r   <= $signed(min_ext << 1);
      inc_hi_r   <= $signed((min_ext << 1) - (maj_ext << 1));
      // A negative major delta is traced from the target end.
      if ((xmaj && !dx[COORD_W]) || (!xmaj && !dy[COORD_W])) begin
        x_r   <= ocol_r;
        y_r   <= orow_r;
        end_r <= xmaj ? tcol_r : trow_r;
      end else begin
        x_r   <= tcol_r;
        y_r   <= trow_r;
        end_r <= xmaj ? ocol_r : orow_r;
      end
    end else if (walk_en && !at_end) begin
      if (err_r <= 0) begin
        err_r <= err_r + inc_lo_r;
        if (xmaj_r) x_r <= x_r + 1'b1;
        else        y_r <= y_r + 1'b1;
      end else begin
        err_r <= err_r + inc_hi_r;
        if (xmaj_r) begin
          x_r <= x_r + 1'b1;
          y_r <= minor_up_r ? y_r + 1'b1 : y_r - 1'b1;
        end else begin
          y_r <= y_r + 1'b1;
          x_r <= minor_up_r ? x_r + 1'b1 : x_r - 1'b1;
        end
      end
    end
  end

  // ---------------- occupancy memory ----------------
  logic          inb;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_in_img, rd_bit;

  assign inb       = (32'(x_r) < IMAGE_SIZE) && (32'(y_r) < IMAGE_SIZE);
  assign rd_addr   = inb ? AW'(32'(y_r) * IMAGE_SIZE + 32'(x_r)) : '0;
  assign wr_in_img = (32'(in_data.col) < IMAGE_SIZE) && (32'(in_data.row) < IMAGE_SIZE);
  assign wr_addr   = wr_in_img ?
                     AW'(32'(in_data.row) * IMAGE_SIZE + 32'(in_data.col)) : '0;

  grc_occ_mem #(
    .IMAGE_SIZE (IMAGE_SIZE),
    .AW         (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_acc && wr_in_img),
    .wr_addr (wr_addr),
    .wr_data (in_data.pixel_value == OCCUPIED_VALUE),
    .rd_addr (rd_addr),
    .rd_data (rd_bit)
  );

  // ---------------- distance and minimum ----------------
  logic signed [COORD_W:0]     dc, dr;
  logic signed [2*COORD_W+1:0] pc, pr;
  logic [DIST_W-1:0]           sq_dist;

  assign dc      = $signed({1'b0, x_r}) - $signed({1'b0, ocol_r});
  assign dr      = $signed({1'b0, y_r}) - $signed({1'b0, orow_r});
  assign pc      = dc * dc;
  assign pr      = dr * dr;
  assign sq_dist = DIST_W'(sq_c_r) + DIST_W'(sq_r_r);

  always_ff @(posedge clk) begin
    sq_c_r <= pc[SQ_W-1:0];
    sq_r_r <= pr[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      pv_r <= walk_en && inb;
      if (setup_en) begin
        hit_r <= 1'b0;
      end else if (pv_r && rd_bit) begin
        hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pv_r && rd_bit && (!hit_r || sq_dist < best_r)) begin
      best_r <= sq_dist;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.hit             <= hit_r;
      out_data_r.min_sq_distance <= hit_r ? best_r : NO_HIT;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/grc_checker.sv =====
`timescale 1ns / 1ps

module grc_checker import grc_pkg::*; #(
  parameter int IMAGE_SIZE = IMAGE_SIZE_DEF
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  localparam logic [DIST_W-1:0] NO_HIT = grc_no_hit(IMAGE_SIZE);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_no_hit_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.min_sq_distance == NO_HIT)
    else $error("miss result carries a wrong distance");

  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> out_data.min_sq_distance <= 17'd130050)
    else $error("hit distance out of range");

  a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.kind == KIND_CAST |=> in_stall)
    else $error("cast transaction did not make the block busy");

  a_result_from_cast: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a cast in progress");

endmodule

bind grid_ray_cast_depth grc_checker #(.IMAGE_SIZE(IMAGE_SIZE)) u_grc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== test/tb_grid_ray_cast_depth.sv =====
`timescale 1ns / 1ps

module tb_grid_ray_cast_depth;
  import grc_pkg::*;

  localparam int IMG = IMAGE_SIZE_DEF;
  localparam int IMG_AREA = IMG * IMG;
  localparam logic [DIST_W-1:0] NO_HIT_DIST =
    (IMG_AREA > int'(DIST_MAX)) ? DIST_MAX : DIST_W'(IMG_AREA);
  localparam logic [CFG_AW-1:0] ADDR_ORIGIN_COL = {REG_ORIGIN_COL, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_ORIGIN_ROW = {REG_ORIGIN_ROW, 2'b00};
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 225;
  localparam int SINK_HOLD_AT = 60;
  localparam int SINK_HOLD_CYCLES = 1200;

  typedef enum logic [1:0] {
    STEP_WRITE,
    STEP_CAST,
    STEP_ORIGIN
  } step_kind_t;

  // For origin steps, col and row carry the new origin.
  typedef struct packed {
    step_kind_t        kind;
    logic [7:0]        col;
    logic [7:0]        row;
    logic [7:0]        value;
    logic              typed;
    logic              hit;
    logic [DIST_W-1:0] exp_dist;
  } dir_step_t;

  localparam int DIR_N = 26;
  localparam dir_step_t DIR_TAB [DIR_N] = '{
    '{STEP_CAST,   8'd127, 8'd127, 8'd0,   1'b1, 1'b0, 17'd65536},
    '{STEP_WRITE,  8'd127, 8'd127, 8'd255, 1'b0, 1'b0, 17'd0},
    '{STEP_CAST,   8'd127, 8'd127, 8'hA5,  1'b1, 1'b1, 17'd0},
    '{STEP_WRITE,  8'd127, 8'd127, 8'd254, 1'b0, 1'b0, 17'd0},
    '{STEP_CAST,   8'd127, 8'd0,   8'd0,   1'b1, 1'b0, 17'd65536},
    '{STEP_WRITE,  8'd127, 8'd0,   8'd255, 1'b0, 1'b0, 17'd0},
    '{STEP_CAST,   8'd127, 8'd0,   8'd255, 1'b1, 1'b1, 17'd16129},
    '{STEP_CAST,   8'd200, 8'd60,  8'd0,   1'b0, 1'b0, 17'd0},
    '{STEP_CAST,   8'd40,  8'd10,  8'd0,   1'b0, 1'b0, 17'd0},
    '{STEP_CAST,   8'd250, 8'd140, 8'd0,   1'b0, 1'b0, 17'd0},
    '{STEP_CAST,   8'd120, 8'd250, 8'd0,   1'b0, 1'b0, 17'd0},
    '{STEP_CAST,   8'd10,  8'd200, 8'd0,   1'b0, 1'b0, 17'd0},
    '{STEP_ORIGIN, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 17'd0},
    '{STEP_WRITE,  8'd127, 8'd0,   8'd0,   1'b0, 1'b0, 17'd0},
    '{STEP_CAST,   8'd255, 8'd0,   8'd0,   1'b1, 1'b0, 17'd65536},
    '{STEP_WRITE,  8'd255, 8'd0,   8'd255, 1'b0, 1'b0, 17'd0},
    '{STEP_CAST,   8'd255, 8'd0,   8'd0,   1'b1, 1'b1, 17'd65025},
    '{STEP_WRITE,  8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 17'd0},
    '{STEP_CAST,   8'd255, 8'd255, 8'd0,   1'b1, 1'b1, 17'd130050},
    '{STEP_ORIGIN, 8'd255, 8'd255, 8'd0,   1'b0, 1'b0, 17'd0},
    '{STEP_CAST,   8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 17'd0},
    '{STEP_WRITE,  8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 17'd0},
    '{STEP_ORIGIN, 8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 17'd0},
    '{STEP_CAST,   8'd0,   8'd255, 8'd0,   1'b1, 1'b0, 17'd65536},
    '{STEP_WRITE,  8'd0,   8'd255, 8'd255, 1'b0, 1'b0, 17'd0},
    '{STEP_CAST,   8'd0,   8'd255, 8'd0,   1'b1, 1'b1, 17'd130050}
  };

  localparam logic [7:0] PHASE_COL [5] = '{8'd0, 8'd255, 8'd0,   8'd255, 8'd127};
  localparam logic [7:0] PHASE_ROW [5] = '{8'd0, 8'd255, 8'd255, 8'd0,   8'd127};

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  bit         occ_grid [IMG_AREA];
  logic [7:0] org_c;
  logic [7:0] org_r;
  out_item_t  cast_results_due [$];
  out_item_t  oldest_due;
  int         mismatch_count;

  grid_ray_cast_depth u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("grid_ray_cast_depth test failed");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Walks the line from the origin to the target and keeps the nearest
  // occupied pixel. A negative major delta walks from the target end.
  function automatic out_item_t ray_hit_of(input logic [7:0] tc, input logic [7:0] tr);
    int sx, sy, ex, ey, dx, dy, adx, ady, major, minor, err, x, y, step, k, best, d;
    bit xmaj, found;
    out_item_t res;
    sx = org_c;
    sy = org_r;
    ex = tc;
    ey = tr;
    dx = ex - sx;
    dy = ey - sy;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    step = ((dx < 0 && dy < 0) || (dx > 0 && dy > 0)) ? 1 : -1;
    xmaj = (ady <= adx);
    major = xmaj ? adx : ady;
    minor = xmaj ? ady : adx;
    err = 2 * minor - major;
    if ((xmaj && dx >= 0) || (!xmaj && dy >= 0)) begin
      x = sx;
      y = sy;
    end else begin
      x = ex;
      y = ey;
    end
    found = 1'b0;
    best = 0;
    for (k = 0; k <= major; k++) begin
      if (k > 0) begin
        if (xmaj) x++; else y++;
        if (err <= 0) begin
          err += 2 * minor;
        end else begin
          if (xmaj) y += step; else x += step;
          err += 2 * (minor - major);
        end
      end
      if (x >= 0 && y >= 0 && x < IMG && y < IMG && occ_grid[y * IMG + x]) begin
        d = (x - sx) * (x - sx) + (y - sy) * (y - sy);
        if (!found || d < best) best = d;
        found = 1'b1;
      end
    end
    res.hit = found;
    res.min_sq_distance = found ? DIST_W'(best) : NO_HIT_DIST;
    return res;
  endfunction

  function automatic in_item_t make_item(input logic kind, input logic [7:0] c,
                                         input logic [7:0] r, input logic [7:0] v);
    in_item_t it;
    it.kind = kind;
    it.col = c;
    it.row = r;
    it.pixel_value = v;
    return it;
  endfunction

  // Mostly short random gaps, now and then a run of back-to-back cycles.
  function automatic int pick_gap(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      run = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int c, r;
    it.kind = ($urandom_range(0, 1) == 0) ? KIND_WRITE : KIND_CAST;
    it.pixel_value = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0, 1: begin
        c = $urandom_range(0, 255);
        r = $urandom_range(0, 255);
      end
      2: begin
        // Around the origin, so writes land where rays start.
        c = int'(org_c) + int'($urandom_range(0, 32)) - 16;
        r = int'(org_r) + int'($urandom_range(0, 32)) - 16;
      end
      default: begin
        c = ($urandom_range(0, 1) == 0) ? 0 : 255;
        r = $urandom_range(0, 255);
        if ($urandom_range(0, 1) == 0) begin
          r = c;
          c = $urandom_range(0, 255);
        end
      end
    endcase
    if (c < 0) c = 0;
    if (c > 255) c = 255;
    if (r < 0) r = 0;
    if (r > 255) r = 255;
    if (it.kind == KIND_WRITE && $urandom_range(0, 2) == 0) it.pixel_value = OCCUPIED_VALUE;
    it.col = c[7:0];
    it.row = r[7:0];
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input in_item_t it, input int gap, input bit typed,
                           input out_item_t fixed);
    out_item_t due_item;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.kind == KIND_WRITE) begin
      occ_grid[int'(it.row) * IMG + int'(it.col)] = (it.pixel_value == OCCUPIED_VALUE);
    end else begin
      due_item = typed ? fixed : ray_hit_of(it.col, it.row);
      cast_results_due = {cast_results_due, due_item};
    end
    @(negedge clk);
  endtask

  task automatic apb_xfer(input bit wr, input logic [CFG_AW-1:0] addr,
                          input logic [CFG_DW-1:0] data, output logic [CFG_DW-1:0] rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_origin(input logic [7:0] c, input logic [7:0] r);
    logic [CFG_DW-1:0] rd;
    apb_xfer(1'b1, ADDR_ORIGIN_COL, CFG_DW'(c), rd);
    apb_xfer(1'b1, ADDR_ORIGIN_ROW, CFG_DW'(r), rd);
    org_c = c;
    org_r = r;
    apb_xfer(1'b0, ADDR_ORIGIN_COL, '0, rd);
    if (rd !== CFG_DW'(c)) flag_mismatch($sformatf("origin_col reads %h, wrote %h", rd, c));
    apb_xfer(1'b0, ADDR_ORIGIN_ROW, '0, rd);
    if (rd !== CFG_DW'(r)) flag_mismatch($sformatf("origin_row reads %h, wrote %h", rd, r));
  endtask

  // A write produces no result, so the wait is padded after the last cast
  // result to let one finish before touching the registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (cast_results_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (cast_results_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result hit=%b dist=%0d",
                                out_data.hit, out_data.min_sq_distance));
      end else begin
        oldest_due = cast_results_due.pop_front();
        if (out_data.hit !== oldest_due.hit)
          flag_mismatch($sformatf("hit %b, expected %b", out_data.hit, oldest_due.hit));
        if (out_data.min_sq_distance !== oldest_due.min_sq_distance)
          flag_mismatch($sformatf("min_sq_distance %0d, expected %0d",
                                  out_data.min_sq_distance, oldest_due.min_sq_distance));
      end
    end
  end

  // Result side. After a few dozen results it holds off for a long stretch
  // so that a finished cast backs up into the input channel.
  initial begin : result_sink
    int gap, run, taken;
    out_stall <= 1'b0;
    run = 0;
    taken = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = (taken == SINK_HOLD_AT) ? SINK_HOLD_CYCLES : pick_gap(run);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    out_item_t fixed;
    in_item_t  it;
    int        run, n, ph, c, r;
    bit        keep_clear;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    mismatch_count = 0;
    run = 0;
    org_c = ORIGIN_COL_RST;
    org_r = ORIGIN_ROW_RST;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The image is not cleared by reset, so every pixel is written first.
    // Borders, both diagonals and the center row and column stay clear for
    // the directed rays; elsewhere about one pixel in 128 is occupied.
    for (r = 0; r < IMG; r++) begin
      for (c = 0; c < IMG; c++) begin
        keep_clear = (r == 0) || (c == 0) || (r == IMG - 1) || (c == IMG - 1) ||
                     (r == c) || (r + c == IMG - 1) || (r == 127) || (c == 127);
        if (!keep_clear && $urandom_range(0, 127) == 0)
          it = make_item(KIND_WRITE, 8'(c), 8'(r), OCCUPIED_VALUE);
        else
          it = make_item(KIND_WRITE, 8'(c), 8'(r), 8'($urandom_range(0, 254)));
        send_item(it, 0, 1'b0, '0);
      end
    end

    for (n = 0; n < DIR_N; n++) begin
      fixed.hit = DIR_TAB[n].hit;
      fixed.min_sq_distance = DIR_TAB[n].exp_dist;
      case (DIR_TAB[n].kind)
        STEP_ORIGIN: begin
          settle();
          set_origin(DIR_TAB[n].col, DIR_TAB[n].row);
        end
        STEP_WRITE: begin
          send_item(make_item(KIND_WRITE, DIR_TAB[n].col, DIR_TAB[n].row, DIR_TAB[n].value),
                    pick_gap(run), 1'b0, fixed);
        end
        default: begin
          send_item(make_item(KIND_CAST, DIR_TAB[n].col, DIR_TAB[n].row, DIR_TAB[n].value),
                    pick_gap(run), DIR_TAB[n].typed, fixed);
        end
      endcase
    end

    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph < 5) set_origin(PHASE_COL[ph], PHASE_ROW[ph]);
      else set_origin(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      for (n = 0; n < PHASE_ITEMS; n++) send_item(random_item(), pick_gap(run), 1'b0, '0);
    end

    settle();
    repeat (300) @(negedge clk);
    if (cast_results_due.size() != 0)
      flag_mismatch($sformatf("%0d cast results never arrived", cast_results_due.size()));
    if (mismatch_count == 0) begin
      $display("grid_ray_cast_depth test passed");
    end else begin
      $display("grid_ray_cast_depth test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/grc_pkg.sv
src/grc_occ_mem.sv
src/grid_ray_cast_depth.sv
src/grc_checker.sv
test/tb_grid_ray_cast_depth.sv
